FILE: sv/wfh_pkg.sv
`default_nettype none

package wfh_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 32;
  localparam int unsigned HalfW = 16;

  localparam logic [WordW-1:0] TagRiff      = 32'h5249_4646;
  localparam logic [WordW-1:0] TagWave      = 32'h5741_5645;
  localparam logic [WordW-1:0] TagFmt       = 32'h666D_7420;
  localparam logic [WordW-1:0] FirstChunk   = 32'd12;
  localparam logic [WordW-1:0] MinLastPos   = 32'd43;
  localparam logic [WordW-1:0] RiffEndPos   = 32'd3;
  localparam logic [WordW-1:0] WaveEndPos   = 32'd11;
  localparam logic [WordW:0]   ChunkHdrLen  = 33'd8;
  localparam logic [HalfW-1:0] PcmFormat    = 16'd1;

  // Offsets inside a chunk, counted from its id
  localparam logic [WordW-1:0] OffIdEnd     = 32'd4;
  localparam logic [WordW-1:0] OffSizeEnd   = 32'd8;
  localparam logic [WordW-1:0] OffHdrLast   = 32'd7;
  localparam logic [WordW-1:0] OffFmtLo     = 32'd8;
  localparam logic [WordW-1:0] OffFmtHi     = 32'd9;
  localparam logic [WordW-1:0] OffChLo      = 32'd10;
  localparam logic [WordW-1:0] OffChHi      = 32'd11;
  localparam logic [WordW-1:0] OffRateLo    = 32'd12;
  localparam logic [WordW-1:0] OffRateHi    = 32'd15;
  localparam logic [WordW-1:0] OffBitsLo    = 32'd22;
  localparam logic [WordW-1:0] OffBitsHi    = 32'd23;

  typedef enum logic [3:0] {
    PH_MAGIC = 4'b0001,
    PH_WALK  = 4'b0010,
    PH_FMT   = 4'b0100,
    PH_DONE  = 4'b1000
  } wfh_phase_e;

  typedef enum logic [1:0] {
    VD_OPEN   = 2'd0,
    VD_REJECT = 2'd1,
    VD_ACCEPT = 2'd2
  } wfh_verdict_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } wfh_item_t;

  typedef struct packed {
    logic             header_ok;
    logic [WordW-1:0] rate_hz;
    logic [HalfW-1:0] sample_bits;
    logic [HalfW-1:0] channel_count;
  } wfh_result_t;

endpackage

`default_nettype wire

FILE: sv/wfh_in_reg.sv
`default_nettype none

module wfh_in_reg
  import wfh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           ready_o,
  input  wire wfh_item_t item_i,
  output logic           valid_o,
  input  wire logic      advance_i,
  output wfh_item_t      item_o
);

  logic      valid_q;
  wfh_item_t item_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wfh_parser.sv
`default_nettype none

module wfh_parser
  import wfh_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire wfh_item_t item_i,
  output logic           res_valid_o,
  output wfh_result_t    res_o
);

  logic [WordW-1:0] pos_q, pos_d;
  wfh_phase_e       phase_q, phase_d;
  logic [WordW-1:0] cs_q, cs_d;
  logic [WordW-1:0] id_q, id_d;
  logic [WordW-1:0] size_q, size_d;
  logic [HalfW-1:0] fmt_q, fmt_d;
  logic [HalfW-1:0] ch_q, ch_d;
  logic [WordW-1:0] rate_q, rate_d;
  logic [HalfW-1:0] bits_q, bits_d;
  wfh_verdict_e     verdict_q, verdict_d;

  logic [WordW:0]   diff;
  logic [WordW-1:0] k;
  logic             before_chunk;
  logic [WordW-1:0] id_new;
  logic [WordW-1:0] size_new;
  logic [WordW:0]   next_cs;
  logic [ByteW-1:0] b;

  always_comb begin
    b            = item_i.data_byte;
    diff         = {1'b0, pos_q} - {1'b0, cs_q};
    k            = diff[WordW-1:0];
    before_chunk = diff[WordW];
    id_new       = {id_q[WordW-ByteW-1:0], b};
    size_new     = {b, size_q[WordW-1:ByteW]};
    next_cs      = {1'b0, cs_q} + ChunkHdrLen + {1'b0, size_new};

    pos_d     = pos_q;
    phase_d   = phase_q;
    cs_d      = cs_q;
    id_d      = id_q;
    size_d    = size_q;
    fmt_d     = fmt_q;
    ch_d      = ch_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    verdict_d = verdict_q;

    if (pos_q == '1) begin
      // Overlong header: hold the count, reject if still open
      if (phase_q != PH_DONE) begin
        phase_d   = PH_DONE;
        verdict_d = VD_REJECT;
      end
    end else begin
      pos_d = pos_q + WordW'(1);
      unique case (phase_q)
        PH_MAGIC: begin
          id_d = id_new;
          if (pos_q == RiffEndPos && id_new != TagRiff) begin
            phase_d   = PH_DONE;
            verdict_d = VD_REJECT;
          end else if (pos_q == WaveEndPos) begin
            if (id_new != TagWave) begin
              phase_d   = PH_DONE;
              verdict_d = VD_REJECT;
            end else begin
              phase_d = PH_WALK;
            end
          end
        end
        PH_WALK: begin
          if (!before_chunk) begin
            if (k < OffIdEnd) begin
              id_d = id_new;
            end else if (k < OffSizeEnd) begin
              size_d = size_new;
            end
            if (k == OffHdrLast) begin
              if (id_q == TagFmt) begin
                phase_d = PH_FMT;
              end else if (next_cs[WordW]) begin
                // Skip runs past the top of the address space
                phase_d   = PH_DONE;
                verdict_d = VD_REJECT;
              end else begin
                cs_d = next_cs[WordW-1:0];
              end
            end
          end
        end
        PH_FMT: begin
          if (k == OffFmtLo || k == OffFmtHi) begin
            fmt_d = {b, fmt_q[HalfW-1:ByteW]};
          end else if (k == OffChLo || k == OffChHi) begin
            ch_d = {b, ch_q[HalfW-1:ByteW]};
          end else if (k >= OffRateLo && k <= OffRateHi) begin
            rate_d = {b, rate_q[WordW-1:ByteW]};
          end else if (k == OffBitsLo || k == OffBitsHi) begin
            bits_d = {b, bits_q[HalfW-1:ByteW]};
          end
          if (k == OffBitsHi) begin
            phase_d   = PH_DONE;
            verdict_d = (fmt_q == PcmFormat) ? VD_ACCEPT : VD_REJECT;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    res_o.header_ok     = (verdict_d == VD_ACCEPT) && (pos_q >= MinLastPos);
    res_o.rate_hz       = res_o.header_ok ? rate_d : '0;
    res_o.sample_bits   = res_o.header_ok ? bits_d : '0;
    res_o.channel_count = res_o.header_ok ? ch_d : '0;
  end

  assign res_valid_o = fire_i && item_i.last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_MAGIC;
      cs_q      <= FirstChunk;
      id_q      <= '0;
      size_q    <= '0;
      fmt_q     <= '0;
      ch_q      <= '0;
      rate_q    <= '0;
      bits_q    <= '0;
      verdict_q <= VD_OPEN;
    end else if (fire_i) begin
      if (item_i.last_byte) begin
        // Verdict given: restart for the next header
        pos_q     <= '0;
        phase_q   <= PH_MAGIC;
        cs_q      <= FirstChunk;
        id_q      <= '0;
        size_q    <= '0;
        fmt_q     <= '0;
        ch_q      <= '0;
        rate_q    <= '0;
        bits_q    <= '0;
        verdict_q <= VD_OPEN;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        cs_q      <= cs_d;
        id_q      <= id_d;
        size_q    <= size_d;
        fmt_q     <= fmt_d;
        ch_q      <= ch_d;
        rate_q    <= rate_d;
        bits_q    <= bits_d;
        verdict_q <= verdict_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/wfh_out_reg.sv
`default_nettype none

module wfh_out_reg
  import wfh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        load_i,
  input  wire wfh_result_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output wfh_result_t      res_o
);

  logic        valid_q;
  wfh_result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/wav_fmt_header_parser.sv
// RIFF/WAVE header parser. Feed the header one byte per transaction on the
// slave stream, tlast on its final byte; that byte yields one result on the
// master stream: tuser is header_ok, and tdata carries sample rate, bits per
// sample and channel count from the first fmt chunk (all zero unless the
// header is at least 44 bytes, has valid magic, a complete fmt chunk and PCM
// format). A byte is taken every cycle unless a last byte waits for a free
// result register; each byte passes an input register and a single parse
// stage into the result register. Only a last byte waits for a free result
// register; other bytes never stall on the master side once parsed.
`default_nettype none

module wav_fmt_header_parser
  import wfh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // [31:0] rate_hz, [47:32] sample_bits,
                                             // [63:48] channel_count
  output logic             m_axis_tuser_o    // header_ok
);

  wfh_item_t   in_item;
  wfh_item_t   stage_item;
  logic        stage_valid;
  logic        advance;
  logic        out_free;
  logic        res_valid;
  wfh_result_t res;
  wfh_result_t out_res;

  assign in_item.data_byte = s_axis_tdata_i;
  assign in_item.last_byte = s_axis_tlast_i;

  // Advance the stage unless a last byte meets a full result register
  assign advance = stage_valid && (!stage_item.last_byte || out_free);

  wfh_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid_i),
    .ready_o   (s_axis_tready_o),
    .item_i    (in_item),
    .valid_o   (stage_valid),
    .advance_i (advance),
    .item_o    (stage_item)
  );

  wfh_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (stage_item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wfh_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tuser_o = out_res.header_ok;
  assign m_axis_tdata_o = {out_res.channel_count, out_res.sample_bits,
                           out_res.rate_hz};

  a_reject_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("rejected header carries non-zero fields");

  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(advance && stage_item.last_byte))
    else $error("result appeared without a parsed last byte");

  a_accept_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> stage_valid)
    else $error("accepted byte lost before the parse stage");

endmodule

`default_nettype wire
